// ===== src/heartbeat_membership_table_assert.svh =====
// Assertion macros for the heartbeat membership table.
// Each macro checks an implication on the rising clock edge and is
// disabled while reset is high.
`ifndef HEARTBEAT_MEMBERSHIP_TABLE_ASSERT_SVH
`define HEARTBEAT_MEMBERSHIP_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define HMT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heartbeat membership table assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define HMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heartbeat membership table assertion failed");
`else
`define HMT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HMT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/hmt_pkg.sv =====
`default_nettype none

package hmt_pkg;

   // Default number of table slots.
   localparam int DEFAULT_TABLE_DEPTH = 32;

   // Configuration port address width: three 32-bit registers.
   localparam int CSR_ADDR_W = 4;

   // Register indexes.
   localparam logic [1:0] CSR_TIMEOUT   = 2'd0;
   localparam logic [1:0] CSR_SELF_ID   = 2'd1;
   localparam logic [1:0] CSR_SELF_PORT = 2'd2;

   // Register reset values.
   localparam logic [15:0] TIMEOUT_RESET = 16'd2;

   // Result event codes.
   localparam logic [2:0] EVT_ADDED      = 3'd0;
   localparam logic [2:0] EVT_REFRESHED  = 3'd1;
   localparam logic [2:0] EVT_IGNORED    = 3'd2;
   localparam logic [2:0] EVT_DROPPED    = 3'd3;
   localparam logic [2:0] EVT_REMOVED    = 3'd4;
   localparam logic [2:0] EVT_SWEEP_DONE = 3'd5;

   // Input transaction payload.
   typedef struct packed {
      logic        mode;
      logic [31:0] member_id;
      logic [15:0] member_port;
      logic [31:0] heartbeat_in;
      logic [31:0] current_time;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [2:0]  event_kind;
      logic [31:0] out_id;
      logic [15:0] out_port;
      logic [31:0] out_heartbeat;
      logic        last;
   } rsp_type;

   // One row of the member table.
   typedef struct packed {
      logic [31:0] id;
      logic [15:0] port;
      logic [31:0] heartbeat;
      logic [31:0] stamp;
   } entry_type;

   // Table access strobes from the sequencer.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic set_valid;
      logic clr_valid;
   } tbl_ctl_type;

   // Configuration register values.
   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [31:0] self_id;
      logic [15:0] self_port;
   } cfg_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== src/heartbeat_membership_table.sv =====
// Flow: an accepted transaction scans every slot in order, then presents its final result; a sweep
// presents the removal of each aged non-key slot as it is checked, since one compare unit checks a row
// a cycle while no removal waits for the output register to drain. No new transaction is taken until
// the final result has entered the output register.
// Reset: synchronous, active high; the table empties at once, own heartbeat clears and the
// registers return to timeout 2, self id 0 and self port 0.
`default_nettype none
`include "heartbeat_membership_table_assert.svh"

module heartbeat_membership_table
   import hmt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  req_type               req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  rsp_stall,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   cfg_type          cfg_ff, cfg_in;
   logic [1:0]       csr_idx;
   logic             csr_wr;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             out_free;
   logic             emit_valid;
   rsp_type          emit_data;
   tbl_ctl_type      tbl_ctl;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] clr_addr;
   logic [IDX_W-1:0] chk_addr;
   entry_type        wr_entry;
   entry_type        rd_entry;
   logic             chk_valid;

   // Configuration registers: written in the access cycle of an APB write.
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_TIMEOUT:   cfg_in.timeout_ticks = csr_pwdata[15:0];
            CSR_SELF_ID:   cfg_in.self_id       = csr_pwdata;
            CSR_SELF_PORT: cfg_in.self_port     = csr_pwdata[15:0];
            default:       cfg_in               = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_TIMEOUT:   csr_prdata = {16'b0, cfg_ff.timeout_ticks};
         CSR_SELF_ID:   csr_prdata = cfg_ff.self_id;
         CSR_SELF_PORT: csr_prdata = {16'b0, cfg_ff.self_port};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{timeout_ticks: TIMEOUT_RESET, self_id: '0, self_port: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Output register: takes a new result whenever the current one leaves.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Lookup sequencer with its compare unit.
   hmt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit_data  (emit_data),
      .tbl_ctl    (tbl_ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .clr_addr   (clr_addr),
      .chk_addr   (chk_addr),
      .wr_entry   (wr_entry),
      .rd_entry   (rd_entry),
      .chk_valid  (chk_valid)
   );

   // Member table storage.
   hmt_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tbl_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .clr_addr  (clr_addr),
      .chk_addr  (chk_addr),
      .wr_entry  (wr_entry),
      .rd_entry  (rd_entry),
      .chk_valid (chk_valid)
   );

   // An accepted transaction keeps the block busy in the following cycle.
   `HMT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // The sequencer never overwrites a result that is still waiting.
   `HMT_ASSERT_IMPLY(a_no_result_overwrite, clock, reset, emit_valid, out_free)
   // After the final result of a transaction the block is ready again.
   `HMT_ASSERT_NEXT(a_ready_after_last, clock, reset, emit_valid && emit_data.last, !req_stall)

endmodule

`default_nettype wire

// ===== src/hmt_table.sv =====
`default_nettype none

module hmt_table
   import hmt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  tbl_ctl_type      ctl,
   input  logic [IDX_W-1:0] rd_addr,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [IDX_W-1:0] clr_addr,
   input  logic [IDX_W-1:0] chk_addr,
   input  entry_type        wr_entry,
   output entry_type        rd_entry,
   output logic             chk_valid
);

   entry_type               mem [TABLE_DEPTH];
   entry_type               rd_entry_ff;
   logic [TABLE_DEPTH-1:0]  valid_ff;
   logic [TABLE_DEPTH-1:0]  valid_in;

   // Row storage: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

   // Slot valid bits live in flip-flops so that reset empties the table at once.
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clr_valid) begin
         valid_in[clr_addr] = 1'b0;
      end
      if (ctl.set_valid) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign chk_valid = valid_ff[chk_addr];

endmodule

`default_nettype wire

// ===== src/hmt_ctrl.sv =====
`default_nettype none

module hmt_ctrl
   import hmt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   input  req_type          req_data,
   output logic             req_stall,
   input  logic             out_free,
   output logic             emit_valid,
   output rsp_type          emit_data,
   output tbl_ctl_type      tbl_ctl,
   output logic [IDX_W-1:0] rd_addr,
   output logic [IDX_W-1:0] wr_addr,
   output logic [IDX_W-1:0] clr_addr,
   output logic [IDX_W-1:0] chk_addr,
   output entry_type        wr_entry,
   input  entry_type        rd_entry,
   input  logic             chk_valid
);

   localparam int               CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   state_type        state_ff, state_in;
   logic             mode_ff, mode_in;
   logic [31:0]      key_id_ff, key_id_in;
   logic [15:0]      key_port_ff, key_port_in;
   logic [31:0]      key_hb_ff, key_hb_in;
   logic [31:0]      now_ff, now_in;
   logic [31:0]      own_hb_ff, own_hb_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic [31:0]      found_hb_ff, found_hb_in;
   logic             free_ok_ff, free_ok_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   logic             slot_valid;
   logic             key_hit;
   logic [31:0]      age;
   logic             aged;
   logic             remove_hit;
   logic             hold;
   logic             issue;
   logic             hb_newer;

   // Compare unit: checks the row read in the previous step against the key.
   always_comb begin
      slot_valid = rd_vld_ff && chk_valid;
      key_hit    = slot_valid && (rd_entry.id == key_id_ff)
                   && (rd_entry.port == key_port_ff);
      age        = now_ff - rd_entry.stamp;
      aged       = age > {16'b0, cfg.timeout_ticks};
      remove_hit = mode_ff && slot_valid && !key_hit && aged;
      hold       = remove_hit && !out_free;
      issue      = idx_ff < DEPTH_C;
      hb_newer   = key_hb_ff > found_hb_ff;
   end

   assign chk_addr = rd_idx_ff;
   assign clr_addr = rd_idx_ff;
   assign rd_addr  = idx_ff[IDX_W-1:0];
   assign wr_entry = '{id: key_id_ff, port: key_port_ff, heartbeat: key_hb_ff,
                       stamp: now_ff};

   // Sequencer: next state, table strobes and result generation.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_id_in    = key_id_ff;
      key_port_in  = key_port_ff;
      key_hb_in    = key_hb_ff;
      now_in       = now_ff;
      own_hb_in    = own_hb_ff;
      idx_in       = idx_ff;
      rd_vld_in    = rd_vld_ff;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_hb_in  = found_hb_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      req_stall    = 1'b1;
      tbl_ctl      = '0;
      wr_addr      = free_idx_ff;
      emit_valid   = 1'b0;
      emit_data    = '{event_kind: EVT_REMOVED, out_id: rd_entry.id,
                       out_port: rd_entry.port, out_heartbeat: rd_entry.heartbeat,
                       last: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            rd_vld_in = 1'b0;
            if (req_valid) begin
               // A sweep looks up the self entry with the next own heartbeat.
               mode_in = req_data.mode;
               if (req_data.mode) begin
                  key_id_in   = cfg.self_id;
                  key_port_in = cfg.self_port;
                  key_hb_in   = own_hb_ff + 32'd1;
               end else begin
                  key_id_in   = req_data.member_id;
                  key_port_in = req_data.member_port;
                  key_hb_in   = req_data.heartbeat_in;
               end
               now_in     = req_data.current_time;
               idx_in     = '0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (!hold) begin
               // Read the next row while the previous one is checked.
               tbl_ctl.rd_en = issue;
               rd_vld_in     = issue;
               rd_idx_in     = idx_ff[IDX_W-1:0];
               if (issue) begin
                  idx_in = idx_ff + CNT_W'(1);
               end
               if (rd_vld_ff) begin
                  if (key_hit && !found_ff) begin
                     found_in     = 1'b1;
                     found_idx_in = rd_idx_ff;
                     found_hb_in  = rd_entry.heartbeat;
                  end
                  if ((!slot_valid || remove_hit) && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = rd_idx_ff;
                  end
                  if (remove_hit) begin
                     tbl_ctl.clr_valid = 1'b1;
                     emit_valid        = 1'b1;
                  end
                  if (rd_idx_ff == LAST_IDX) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end

         ST_FINISH: begin
            emit_data.out_id   = key_id_ff;
            emit_data.out_port = key_port_ff;
            emit_data.last     = 1'b1;
            // Resolve the lookup: refresh, ignore, insert or drop.
            if (found_ff) begin
               wr_addr = found_idx_ff;
               if (hb_newer) begin
                  emit_data.event_kind    = EVT_REFRESHED;
                  emit_data.out_heartbeat = key_hb_ff;
               end else begin
                  emit_data.event_kind    = EVT_IGNORED;
                  emit_data.out_heartbeat = found_hb_ff;
               end
            end else if (free_ok_ff) begin
               emit_data.event_kind    = EVT_ADDED;
               emit_data.out_heartbeat = key_hb_ff;
            end else begin
               emit_data.event_kind    = EVT_DROPPED;
               emit_data.out_heartbeat = key_hb_ff;
            end
            if (mode_ff) begin
               emit_data.event_kind    = EVT_SWEEP_DONE;
               emit_data.out_heartbeat = key_hb_ff;
            end
            if (out_free) begin
               emit_valid        = 1'b1;
               tbl_ctl.wr_en     = (found_ff && hb_newer) || (!found_ff && free_ok_ff);
               tbl_ctl.set_valid = !found_ff && free_ok_ff;
               if (mode_ff) begin
                  own_hb_in = key_hb_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state is reset; key and lookup payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         own_hb_ff  <= '0;
         rd_vld_ff  <= 1'b0;
         found_ff   <= 1'b0;
         free_ok_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         own_hb_ff  <= own_hb_in;
         rd_vld_ff  <= rd_vld_in;
         found_ff   <= found_in;
         free_ok_ff <= free_ok_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      key_id_ff    <= key_id_in;
      key_port_ff  <= key_port_in;
      key_hb_ff    <= key_hb_in;
      now_ff       <= now_in;
      rd_idx_ff    <= rd_idx_in;
      found_idx_ff <= found_idx_in;
      found_hb_ff  <= found_hb_in;
      free_idx_ff  <= free_idx_in;
   end

endmodule

`default_nettype wire
